// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define RC4_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define RC4_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rc4_pkg.sv =====
// Shared types and constants of the RC4 stream cipher block.
// No dependencies; used by the controller, datapath and top level.
package rc4_pkg;

   localparam int BYTE_W      = 8;
   localparam int PERM_DEPTH  = 256;
   localparam int PERM_AW     = 8;
   localparam int KEY_MAX_DEF = 256;

   // Function code of an input word
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_D_J,
      ST_D_SW,
      ST_D_FIN,
      ST_D_HOLD,
      ST_K_RD,
      ST_K_CALC,
      ST_K_W1,
      ST_K_W2
   } rc4_state_type;

   // Datapath step selected by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_DATA_J,
      OP_DATA_SWAP,
      OP_DATA_FIN,
      OP_SCHED_READ,
      OP_SCHED_CALC,
      OP_SCHED_W1,
      OP_SCHED_W2
   } rc4_op_type;

   typedef struct packed {
      rc4_op_type op;
      logic       byte_load;     // capture data word, advance i
      logic       key_write;     // store key word, bump count
      logic       sched_start;   // identity table, clear indices
      logic       sched_end;     // clear key count
      logic       out_load;      // load result register
      logic       out_from_hold; // result comes from the hold register
      logic       hold_save;     // park keystream result
   } rc4_cmd_type;

   typedef struct packed {
      logic key_full;
      logic n_last;
      logic out_free;
   } rc4_sts_type;

endpackage

// ===== hdl/rc4_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the permutation table and the key store.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rc4_ctrl.sv =====
// Controller of the RC4 block: key intake, key schedule and data steps.
// Depends on rc4_pkg; drives rc4_dp through rc4_cmd_type.
module rc4_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   input  logic                 req_last_key,
   output logic                 req_stall,
   input  rc4_pkg::rc4_sts_type sts,
   output rc4_pkg::rc4_cmd_type cmd
);

   rc4_pkg::rc4_state_type state_ff;
   rc4_pkg::rc4_state_type state_in;
   logic                   accept;

   assign req_stall = (state_ff != rc4_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == rc4_pkg::FUNC_DATA) begin
                  state_in = rc4_pkg::ST_D_J;
               end else if (req_last_key) begin
                  state_in = rc4_pkg::ST_K_RD;
               end
            end
         end
         rc4_pkg::ST_D_J:    state_in = rc4_pkg::ST_D_SW;
         rc4_pkg::ST_D_SW:   state_in = rc4_pkg::ST_D_FIN;
         rc4_pkg::ST_D_FIN: begin
            state_in = sts.out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_D_HOLD;
         end
         rc4_pkg::ST_D_HOLD: begin
            if (sts.out_free) begin
               state_in = rc4_pkg::ST_IDLE;
            end
         end
         rc4_pkg::ST_K_RD:   state_in = rc4_pkg::ST_K_CALC;
         rc4_pkg::ST_K_CALC: state_in = rc4_pkg::ST_K_W1;
         rc4_pkg::ST_K_W1:   state_in = rc4_pkg::ST_K_W2;
         rc4_pkg::ST_K_W2: begin
            state_in = sts.n_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
         end
         default:            state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      cmd.op = rc4_pkg::OP_NONE;
      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == rc4_pkg::FUNC_DATA) begin
                  cmd.byte_load = 1'b1;
               end else begin
                  cmd.key_write   = !sts.key_full;
                  cmd.sched_start = req_last_key;
               end
            end
         end
         rc4_pkg::ST_D_J:    cmd.op = rc4_pkg::OP_DATA_J;
         rc4_pkg::ST_D_SW:   cmd.op = rc4_pkg::OP_DATA_SWAP;
         rc4_pkg::ST_D_FIN: begin
            cmd.op        = rc4_pkg::OP_DATA_FIN;
            cmd.out_load  = sts.out_free;
            cmd.hold_save = !sts.out_free;
         end
         rc4_pkg::ST_D_HOLD: begin
            cmd.out_load      = sts.out_free;
            cmd.out_from_hold = 1'b1;
         end
         rc4_pkg::ST_K_RD:   cmd.op = rc4_pkg::OP_SCHED_READ;
         rc4_pkg::ST_K_CALC: cmd.op = rc4_pkg::OP_SCHED_CALC;
         rc4_pkg::ST_K_W1:   cmd.op = rc4_pkg::OP_SCHED_W1;
         rc4_pkg::ST_K_W2: begin
            cmd.op        = rc4_pkg::OP_SCHED_W2;
            cmd.sched_end = sts.n_last;
         end
         default:            cmd.op = rc4_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== hdl/rc4_dp.sv =====
// Datapath of the RC4 block: permutation RAM with valid bits, key store,
// indices, schedule counters and result register. Depends on rc4_pkg, rc4_ram.
module rc4_dp #(
   parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rc4_pkg::BYTE_W-1:0]  req_byte_in,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [rc4_pkg::BYTE_W-1:0]  rsp_byte_out,
   input  rc4_pkg::rc4_cmd_type        cmd,
   output rc4_pkg::rc4_sts_type        sts
);

   localparam int KA = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int CW = $clog2(KEY_MAX + 1);
   localparam int BW = rc4_pkg::BYTE_W;
   localparam int PA = rc4_pkg::PERM_AW;

   // Indices and working registers
   logic [PA-1:0] i_ff, j_ff, acc_ff, n_ff;
   logic [BW-1:0] a_ff, b_ff, byte_ff, hold_ff;
   logic          hit_i_ff, hit_j_ff;
   logic [KA-1:0] pos_ff;
   logic [CW-1:0] key_count_ff;
   logic          rsp_valid_ff;
   logic [BW-1:0] rsp_byte_ff;

   // Permutation table: RAM plus one valid bit per entry
   logic [rc4_pkg::PERM_DEPTH-1:0] perm_valid_ff;
   logic          rd_valid_ff;
   logic [PA-1:0] rd_addr_ff;
   logic          perm_we;
   logic [PA-1:0] perm_waddr, perm_raddr;
   logic [BW-1:0] perm_wdata, perm_ram_rd, perm_rd;

   logic [BW-1:0] key_rd;
   logic [KA-1:0] key_waddr;
   logic [CW-1:0] pos_inc;
   logic [PA-1:0] acc_new, t_addr;
   logic [BW-1:0] ks_sel, ks_word;

   rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_waddr),
      .wr_data (perm_wdata),
      .rd_addr (perm_raddr),
      .rd_data (perm_ram_rd)
   );

   assign key_waddr = key_count_ff[KA-1:0];

   rc4_ram #(.WIDTH(BW), .DEPTH(KEY_MAX)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.key_write),
      .wr_addr (key_waddr),
      .wr_data (req_byte_in),
      .rd_addr (pos_ff),
      .rd_data (key_rd)
   );

   // An entry never written since the last schedule holds its own index
   assign perm_rd = rd_valid_ff ? perm_ram_rd : rd_addr_ff;

   assign acc_new = acc_ff + perm_rd + key_rd;
   assign t_addr  = a_ff + perm_rd;

   // Read address and write port selection
   always_comb begin
      perm_raddr = i_ff + PA'(1);
      perm_we    = 1'b0;
      perm_waddr = i_ff;
      perm_wdata = perm_rd;
      case (cmd.op)
         rc4_pkg::OP_DATA_J:     perm_raddr = j_ff + perm_rd;
         rc4_pkg::OP_DATA_SWAP: begin
            perm_raddr = t_addr;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd;
         end
         rc4_pkg::OP_DATA_FIN: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = a_ff;
         end
         rc4_pkg::OP_SCHED_READ: perm_raddr = n_ff;
         rc4_pkg::OP_SCHED_CALC: perm_raddr = acc_new;
         rc4_pkg::OP_SCHED_W1: begin
            perm_we    = 1'b1;
            perm_waddr = n_ff;
            perm_wdata = perm_rd;
         end
         rc4_pkg::OP_SCHED_W2: begin
            perm_we    = 1'b1;
            perm_waddr = acc_ff;
            perm_wdata = a_ff;
         end
         default: perm_raddr = i_ff + PA'(1);
      endcase
   end

   // Valid bits follow the RAM; a reset or a schedule start empties them all at once
   always_ff @(posedge clock) begin
      if (reset || cmd.sched_start) begin
         perm_valid_ff <= '0;
      end else if (perm_we) begin
         perm_valid_ff[perm_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= perm_valid_ff[perm_raddr];
      rd_addr_ff  <= perm_raddr;
   end

   // Indices and key count
   assign pos_inc = CW'(pos_ff) + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
      end else begin
         if (cmd.sched_start) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (cmd.byte_load) begin
            i_ff <= i_ff + PA'(1);
         end else if (cmd.op == rc4_pkg::OP_DATA_J) begin
            j_ff <= j_ff + perm_rd;
         end
         if (cmd.sched_end) begin
            key_count_ff <= '0;
         end else if (cmd.key_write) begin
            key_count_ff <= key_count_ff + CW'(1);
         end
      end
   end

   // Schedule counters and data-step working registers
   always_ff @(posedge clock) begin
      if (cmd.sched_start) begin
         n_ff   <= '0;
         acc_ff <= '0;
         pos_ff <= '0;
      end
      if (cmd.byte_load) begin
         byte_ff <= req_byte_in;
      end
      case (cmd.op)
         rc4_pkg::OP_DATA_J:     a_ff <= perm_rd;
         rc4_pkg::OP_DATA_SWAP: begin
            b_ff     <= perm_rd;
            hit_i_ff <= (t_addr == i_ff);
            hit_j_ff <= (t_addr == j_ff);
         end
         rc4_pkg::OP_SCHED_CALC: begin
            a_ff   <= perm_rd;
            acc_ff <= acc_new;
         end
         rc4_pkg::OP_SCHED_W2: begin
            n_ff   <= n_ff + PA'(1);
            pos_ff <= (pos_inc >= key_count_ff) ? '0 : pos_inc[KA-1:0];
         end
         default: begin
         end
      endcase
      if (cmd.hold_save) begin
         hold_ff <= ks_word;
      end
   end

   // Keystream byte after the swap; the RAM read raced the two writes
   assign ks_sel  = hit_j_ff ? a_ff : (hit_i_ff ? b_ff : perm_rd);
   assign ks_word = byte_ff ^ ks_sel;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_byte_ff <= cmd.out_from_hold ? hold_ff : ks_word;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;

   assign sts.key_full = (key_count_ff == CW'(KEY_MAX));
   assign sts.n_last   = (n_ff == PA'(rc4_pkg::PERM_DEPTH - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== hdl/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher block.
// Depends on rc4_pkg, rc4_ctrl, rc4_dp (and rc4_ram below it).
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_func, req_byte_in, req_last_key
//   rsp      out        rsp_valid/rsp_stall   rsp_byte_out
//
// A key word gives no result. The last key word starts
// the key schedule: 256 swap steps, each two reads of the permutation RAM
// (which has a single read port) and two writes. A data word makes three
// dependent reads of that RAM, then the second swap write.
// Reset is synchronous and returns the table to identity at once.
// A stalled result is held in the output register; one more finished
// result is parked internally and the input stalls until it moves out.
module rc4_stream_cipher #(
   parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [rc4_pkg::BYTE_W-1:0] req_byte_in,
   input  logic                       req_last_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0] rsp_byte_out
);

   rc4_pkg::rc4_cmd_type cmd;
   rc4_pkg::rc4_sts_type sts;

   rc4_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_func     (req_func),
      .req_last_key (req_last_key),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   rc4_dp #(.KEY_MAX(KEY_MAX)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_byte_in  (req_byte_in),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_byte_out (rsp_byte_out),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

// ===== hdl/rc4_checker.sv =====
// Port-level checker for rc4_stream_cipher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rc4_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_func,
   input logic [7:0] req_byte_in,
   input logic       req_last_key,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte_out
);

   // A stalled result word stays put
   `RC4_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_out), "result changed under stall")

   // Reset empties the result register
   `RC4_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // A key word never produces a result
   `RC4_ASSERT(a_key_silent, clock, reset, req_valid && !req_stall && !req_func && !rsp_valid |=> !rsp_valid, "key word gave a result")

   // A data word or a final key word keeps the block busy next cycle
   `RC4_ASSERT(a_busy, clock, reset, req_valid && !req_stall && (req_func || req_last_key) |=> req_stall, "input not stalled while busy")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
